/* sv/blr_pkg.sv */
`default_nettype none
package blr_pkg;

  // hold length after each turn of the ramp, as loaded into the 4-bit counter
  localparam int unsigned HOLD_TICKS = 10;
  localparam logic [3:0]  HOLD_LOAD  = 4'(HOLD_TICKS);

  localparam int unsigned QUEUE_DEPTH_DEF = 4;
  localparam int unsigned LEVEL_W = 8;

  typedef enum logic [2:0] {
    REG_ENABLE = 3'd0,
    REG_STEP   = 3'd1,
    REG_MIN    = 3'd2,
    REG_MAX    = 3'd3,
    REG_RED    = 3'd4,
    REG_GREEN  = 3'd5,
    REG_BLUE   = 3'd6,
    REG_WHITE  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic       enable;
    logic [6:0] step;
    logic [7:0] min_level;
    logic [7:0] max_level;
  } ramp_cfg_t;

  typedef struct packed {
    logic [7:0] white;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } color_t;

  // exact floor(p / 255) for p up to 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] p);
    logic [16:0] s;
    s = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
    return s[15:8];
  endfunction

endpackage
`default_nettype wire

/* sv/blr_front.sv */
`default_nettype none
module blr_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_restart,
  output logic                   in_ready,
  input  wire blr_pkg::ramp_cfg_t cfg,
  input  wire logic              q_full,
  output logic                   push_valid,
  output logic [7:0]             push_level
);
  import blr_pkg::*;

  logic [7:0] level_r, level_nxt;
  logic       falling_r, falling_nxt;
  logic [3:0] hold_r, hold_nxt;

  logic       accept;
  logic [7:0] lvl0;
  logic       fall0;
  logic [7:0] lvl_hi;
  logic [7:0] lvl_c;
  logic [8:0] up_sum;
  logic [8:0] down_lim;
  logic       step_nz;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    lvl0     = in_restart ? cfg.min_level : level_r;
    fall0    = in_restart ? 1'b0 : falling_r;
    // max bound first, then min bound
    lvl_hi   = (lvl0 > cfg.max_level) ? cfg.max_level : lvl0;
    lvl_c    = (lvl_hi < cfg.min_level) ? cfg.min_level : lvl_hi;
    step_nz  = (cfg.step != 7'd0);
    up_sum   = {1'b0, lvl_c} + {2'b00, cfg.step};
    down_lim = {1'b0, cfg.min_level} + {2'b00, cfg.step};
  end

  always_comb begin
    level_nxt   = level_r;
    falling_nxt = falling_r;
    hold_nxt    = hold_r;
    if (accept) begin
      level_nxt   = lvl0;
      falling_nxt = fall0;
      if (cfg.enable) begin
        level_nxt = lvl_c;
        if (hold_r != 4'd0) begin
          hold_nxt = hold_r - 4'd1;
        end else if (!fall0) begin
          if (step_nz && (up_sum >= {1'b0, cfg.max_level})) begin
            level_nxt   = cfg.max_level;
            falling_nxt = 1'b1;
            hold_nxt    = HOLD_LOAD;
          end else begin
            level_nxt = up_sum[7:0];
          end
        end else begin
          if (step_nz && ({1'b0, lvl_c} <= down_lim)) begin
            level_nxt   = cfg.min_level;
            falling_nxt = 1'b0;
            hold_nxt    = HOLD_LOAD;
          end else begin
            level_nxt = lvl_c - {1'b0, cfg.step};
          end
        end
      end
    end
  end

  assign push_valid = accept && cfg.enable;
  assign push_level = lvl_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r   <= 8'd0;
      falling_r <= 1'b0;
      hold_r    <= 4'd0;
    end else begin
      level_r   <= level_nxt;
      falling_r <= falling_nxt;
      hold_r    <= hold_nxt;
    end
  end

endmodule
`default_nettype wire

/* sv/blr_queue.sv */
`default_nettype none
module blr_queue #(
  parameter int unsigned DEPTH = blr_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned WIDTH = blr_pkg::LEVEL_W
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  output logic                  pop_valid,
  output logic [WIDTH-1:0]      pop_data,
  input  wire logic             pop_ready
);
  import blr_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [AW-1:0]    wr_r, wr_nxt;
  logic [AW-1:0]    rd_r, rd_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full      = (cnt_r == CW'(DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_data  = slot_r[rd_r];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop_valid && pop_ready;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == LAST) ? '0 : wr_r + AW'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == LAST) ? '0 : rd_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

/* sv/blr_back.sv */
`default_nettype none
module blr_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            pop_valid,
  input  wire logic [7:0]      pop_level,
  output logic                 pop_ready,
  input  wire blr_pkg::color_t targets,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output blr_pkg::color_t      out_color,
  output logic                 out_changed
);
  import blr_pkg::*;

  // product stage
  logic        s1_v_r, s1_v_nxt;
  logic [15:0] prod_r [4];
  // output stage
  logic        out_v_r, out_v_nxt;
  color_t      color_r;
  logic        changed_r;
  color_t      last_r;

  logic   s2_load, s1_load;
  color_t scaled;

  assign s2_load   = s1_v_r && (!out_v_r || out_ready);
  assign s1_load   = !s1_v_r || s2_load;
  assign pop_ready = s1_load;

  always_comb begin
    scaled.red   = div255(prod_r[0]);
    scaled.green = div255(prod_r[1]);
    scaled.blue  = div255(prod_r[2]);
    scaled.white = div255(prod_r[3]);
  end

  always_comb begin
    s1_v_nxt = s1_load ? pop_valid : s1_v_r;
    if (s2_load) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && pop_valid) begin
      prod_r[0] <= 16'(targets.red)   * 16'(pop_level);
      prod_r[1] <= 16'(targets.green) * 16'(pop_level);
      prod_r[2] <= 16'(targets.blue)  * 16'(pop_level);
      prod_r[3] <= 16'(targets.white) * 16'(pop_level);
    end
    if (s2_load) begin
      color_r   <= scaled;
      changed_r <= (scaled != last_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      last_r  <= '0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      if (s2_load) begin
        last_r <= scaled;
      end
    end
  end

  assign out_valid   = out_v_r;
  assign out_color   = color_r;
  assign out_changed = changed_r;

endmodule
`default_nettype wire

/* sv/breathing_led_ramp_unit.sv */
// Breathing ramp for an RGBW LED: a triangle brightness wave with a hold at
// each turn, scaling four target colours by level / 255.
// channels: in_* carries one tick word (restart flag); out_* carries the
//   scaled colour with a changed flag in tuser; cfg_* writes one register
//   per word (enable, step, min, max, then red, green, blue, white targets).
// each tick word updates the ramp state (level, direction, hold count) at the
//   accepting edge, so ticks go back to back while the queue is not full.
// a disabled tick gives no output word but still applies restart.
// an enabled tick reaches out_tvalid through the queue, the product register
//   and the output register, in that order.
// throughput: one word per cycle while out_tready stays high, set by the level
//   update at each accepting edge and the one-word-per-cycle back pipeline.
// when the receiver stalls, the back pipeline holds and the queue, four entries
//   by default, fills; in_tready drops only when the queue is full.
// reset: ramp at level 0, rising, no hold, last colour black, config at its
//   defaults (disabled, step 2, min 0, max 255, targets black).
// config writes are always ready and must only be made while the block is idle
`default_nettype none
module breathing_led_ramp_unit #(
  parameter int unsigned QUEUE_DEPTH = blr_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // tick input
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [0] restart, [7:1] zero
  // colour output
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,   // [7:0] red_out, [15:8] green_out,
                                        // [23:16] blue_out, [31:24] white_out
  output logic [0:0]       out_tuser,   // [0] color_changed
  // register writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);
  import blr_pkg::*;

  // configuration registers
  ramp_cfg_t ramp_r;
  color_t    tgt_r;

  // front to queue
  logic       push_valid;
  logic [7:0] push_level;
  logic       q_full;
  // queue to back
  logic       pop_valid;
  logic       pop_ready;
  logic [7:0] pop_level;

  color_t     color;
  logic       changed;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_r.enable    <= 1'b0;
      ramp_r.step      <= 7'd2;
      ramp_r.min_level <= 8'd0;
      ramp_r.max_level <= 8'd255;
      tgt_r            <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_ENABLE: ramp_r.enable    <= cfg_data[0];
        REG_STEP:   ramp_r.step      <= cfg_data[6:0];
        REG_MIN:    ramp_r.min_level <= cfg_data;
        REG_MAX:    ramp_r.max_level <= cfg_data;
        REG_RED:    tgt_r.red        <= cfg_data;
        REG_GREEN:  tgt_r.green      <= cfg_data;
        REG_BLUE:   tgt_r.blue       <= cfg_data;
        REG_WHITE:  tgt_r.white      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // front: ramp state, clamps the level of each tick
  blr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_restart (in_tdata[0]),
    .in_ready   (in_tready),
    .cfg        (ramp_r),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_level (push_level)
  );

  // short queue of clamped levels between front and back
  blr_queue #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (LEVEL_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_level),
    .full       (q_full),
    .pop_valid  (pop_valid),
    .pop_data   (pop_level),
    .pop_ready  (pop_ready)
  );

  // back: scaling, change detect and output register
  blr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop_valid   (pop_valid),
    .pop_level   (pop_level),
    .pop_ready   (pop_ready),
    .targets     (tgt_r),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_color   (color),
    .out_changed (changed)
  );

  assign out_tdata    = color;
  assign out_tuser[0] = changed;

endmodule
`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import blr_pkg::*;

  // one expected colour word on the output channel
  typedef struct {
    color_t color;
    logic   changed;
  } led_word_t;

  // receiver stall patterns
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_RARE_STALL,
    RX_PERIODIC
  } rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [0] restart, [7:1] zero
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;   // [7:0] red, [15:8] green, [23:16] blue, [31:24] white
  logic [0:0]  out_tuser;   // [0] color_changed
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [7:0]  cfg_data;

  breathing_led_ramp_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // ramp predictor: shadow registers and shadow ramp state
  // ---------------------------------------------------------------------
  ramp_cfg_t  ramp_cfg;
  color_t     target_color;
  logic [7:0] ramp_level;
  logic       ramp_falling;
  logic [3:0] ramp_hold;
  color_t     prev_color;

  led_word_t  expected_colors[$];
  int         mismatches = 0;

  function automatic logic [7:0] scale_channel(logic [7:0] tgt, logic [7:0] lvl);
    int unsigned prod;
    prod = 32'(tgt) * 32'(lvl);
    return 8'(prod / 255);
  endfunction

  // one tick of the breathing ramp; queues the colour word it produces
  task automatic advance_ramp(input logic restart);
    led_word_t word;
    int        nxt;
    if (restart) begin
      ramp_level   = ramp_cfg.min_level;
      ramp_falling = 1'b0;
    end
    if (!ramp_cfg.enable) return;

    // max bound first, then min bound: min above max ends at min
    if (ramp_level > ramp_cfg.max_level) ramp_level = ramp_cfg.max_level;
    if (ramp_level < ramp_cfg.min_level) ramp_level = ramp_cfg.min_level;

    word.color.red   = scale_channel(target_color.red, ramp_level);
    word.color.green = scale_channel(target_color.green, ramp_level);
    word.color.blue  = scale_channel(target_color.blue, ramp_level);
    word.color.white = scale_channel(target_color.white, ramp_level);
    word.changed     = (word.color != prev_color);
    prev_color       = word.color;
    expected_colors.push_back(word);

    // a pending hold only counts down
    if (ramp_hold != 4'd0) begin
      ramp_hold = ramp_hold - 4'd1;
      return;
    end

    if (!ramp_falling) begin
      nxt = int'(ramp_level) + int'(ramp_cfg.step);
      if (ramp_cfg.step != 7'd0 && nxt >= int'(ramp_cfg.max_level)) begin
        ramp_level   = ramp_cfg.max_level;
        ramp_falling = 1'b1;
        ramp_hold    = HOLD_LOAD;
      end else begin
        ramp_level = 8'(nxt);
      end
    end else begin
      nxt = int'(ramp_level) - int'(ramp_cfg.step);
      if (ramp_cfg.step != 7'd0 && nxt <= int'(ramp_cfg.min_level)) begin
        ramp_level   = ramp_cfg.min_level;
        ramp_falling = 1'b0;
        ramp_hold    = HOLD_LOAD;
      end else begin
        ramp_level = 8'(nxt);
      end
    end
  endtask

  // track register writes and accepted ticks at the edges that take them
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_ENABLE: ramp_cfg.enable     = cfg_data[0];
          REG_STEP:   ramp_cfg.step       = cfg_data[6:0];
          REG_MIN:    ramp_cfg.min_level  = cfg_data;
          REG_MAX:    ramp_cfg.max_level  = cfg_data;
          REG_RED:    target_color.red    = cfg_data;
          REG_GREEN:  target_color.green  = cfg_data;
          REG_BLUE:   target_color.blue   = cfg_data;
          REG_WHITE:  target_color.white  = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) advance_ramp(in_tdata[0]);
    end
  end

  // ---------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    // keep the log short if things go badly wrong
    if (mismatches < 40) $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    led_word_t want;
    color_t    got;
    if (rst_n && out_tvalid && out_tready) begin
      got = color_t'(out_tdata);
      if (expected_colors.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h changed=%b", out_tdata, out_tuser[0]));
      end else begin
        want = expected_colors.pop_front();
        if (got.red !== want.color.red)
          report_mismatch($sformatf("red %0d, expected %0d", got.red, want.color.red));
        if (got.green !== want.color.green)
          report_mismatch($sformatf("green %0d, expected %0d", got.green, want.color.green));
        if (got.blue !== want.color.blue)
          report_mismatch($sformatf("blue %0d, expected %0d", got.blue, want.color.blue));
        if (got.white !== want.color.white)
          report_mismatch($sformatf("white %0d, expected %0d", got.white, want.color.white));
        if (out_tuser[0] !== want.changed)
          report_mismatch($sformatf("changed %b, expected %b", out_tuser[0], want.changed));
      end
    end
  end

  // ---------------------------------------------------------------------
  // receiver: picks its own stall pattern, plus a long hold-off on request
  // ---------------------------------------------------------------------
  rx_mode_t rx_mode = RX_ALWAYS;
  int       rx_mode_left = 0;
  int       rx_phase = 0;
  int       rx_hold_left = 0;
  logic     long_stall_req = 1'b0;

  always @(posedge clk) begin
    rx_phase++;
    if (long_stall_req) begin
      long_stall_req = 1'b0;
      rx_hold_left   = 150;
    end
    if (rx_hold_left > 0) begin
      // long hold-off so the queue fills and in_tready drops
      rx_hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_t'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(30, 200);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        RX_ALWAYS:     out_tready <= 1'b1;
        RX_COIN:       out_tready <= 1'($urandom_range(0, 1));
        RX_RARE_STALL: out_tready <= ($urandom_range(0, 7) != 0);
        default:       out_tready <= (rx_phase % 5) < 2;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // sender and register writes
  // ---------------------------------------------------------------------
  logic gaps_on = 1'b1;
  int   burst_left = 0;

  // offer one tick word, in bursts with random gaps, and wait until taken
  task automatic send_tick(input logic restart);
    int gap;
    gap = 0;
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(1, 6);
        burst_left = $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, restart};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // leaves cfg_valid high; the caller lowers it after its last write
  task automatic write_reg(input cfg_reg_t idx, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic apply_cfg(input logic en, input logic [6:0] step,
                           input logic [7:0] lo, input logic [7:0] hi,
                           input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b, input logic [7:0] w);
    write_reg(REG_ENABLE, {7'd0, en});
    write_reg(REG_STEP, {1'b0, step});
    write_reg(REG_MIN, lo);
    write_reg(REG_MAX, hi);
    write_reg(REG_RED, r);
    write_reg(REG_GREEN, g);
    write_reg(REG_BLUE, b);
    write_reg(REG_WHITE, w);
    cfg_valid <= 1'b0;
  endtask

  // stop offering and wait until every expected word is back, plus latency
  task automatic drain_outputs();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // disabled after reset: no output, restart still applied;
  // then enable only, so the reset step and bounds are used with black targets
  task automatic test_reset_defaults();
    send_tick(1'b0);
    send_tick(1'b1);
    drain_outputs();
    write_reg(REG_ENABLE, 8'd1);
    cfg_valid <= 1'b0;
    // black first colour matches the reset colour: changed stays low
    repeat (3) send_tick(1'b0);
    drain_outputs();
  endtask

  // largest step and full targets: overshoot pinned at max, hold, restart in hold
  task automatic test_full_scale();
    apply_cfg(1'b1, 7'd127, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    send_tick(1'b1);
    repeat (4) send_tick(1'b0);
    // restart during the hold: level back to min, hold keeps counting
    send_tick(1'b1);
    repeat (2) send_tick(1'b0);
    drain_outputs();
  endtask

  // min above max: level settles at min
  task automatic test_min_above_max();
    apply_cfg(1'b1, 7'd5, 8'd200, 8'd50, 8'hA5, 8'h5A, 8'h0F, 8'hF0);
    send_tick(1'b1);
    repeat (2) send_tick(1'b0);
    drain_outputs();
  endtask

  // zero step: level never moves and the ramp never turns
  task automatic test_zero_step();
    apply_cfg(1'b1, 7'd0, 8'd10, 8'd240, 8'h80, 8'h40, 8'h20, 8'h01);
    send_tick(1'b1);
    repeat (2) send_tick(1'b0);
    drain_outputs();
  endtask

  // receiver holds off for a long stretch while ticks keep coming
  task automatic test_backpressure();
    apply_cfg(1'b1, 7'd3, 8'd0, 8'd255, pick_byte(), pick_byte(), pick_byte(), pick_byte());
    gaps_on        = 1'b0;
    long_stall_req = 1'b1;
    send_tick(1'b1);
    repeat (40) send_tick(1'b0);
    drain_outputs();
    gaps_on = 1'b1;
  endtask

  // random settings, each followed by a run of ticks with rare restarts
  task automatic test_random_ramps(input int target_ticks);
    int         sent_ticks;
    int         run_len;
    logic       en;
    logic [6:0] step;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] lo;
    logic [7:0] hi;
    sent_ticks = 0;
    while (sent_ticks < target_ticks) begin
      en = ($urandom_range(0, 7) != 0);
      case ($urandom_range(0, 9))
        0:       step = 7'd0;
        1:       step = 7'd127;
        2, 3:    step = 7'($urandom_range(16, 127));
        default: step = 7'($urandom_range(1, 12));
      endcase
      a = pick_byte();
      b = pick_byte();
      // mostly a proper range, sometimes min above max
      if ((a <= b) != ($urandom_range(0, 6) == 0)) begin
        lo = a;
        hi = b;
      end else begin
        lo = b;
        hi = a;
      end
      apply_cfg(en, step, lo, hi, pick_byte(), pick_byte(), pick_byte(), pick_byte());
      gaps_on = ($urandom_range(0, 3) != 0);
      run_len = $urandom_range(30, 120);
      sent_ticks += run_len;
      repeat (run_len) send_tick($urandom_range(0, 19) == 0);
      drain_outputs();
    end
    gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = 8'd0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_ENABLE;
    cfg_data   = 8'd0;

    // predictor starts from the reset state
    ramp_cfg.enable    = 1'b0;
    ramp_cfg.step      = 7'd2;
    ramp_cfg.min_level = 8'd0;
    ramp_cfg.max_level = 8'd255;
    target_color       = '0;
    ramp_level         = 8'd0;
    ramp_falling       = 1'b0;
    ramp_hold          = 4'd0;
    prev_color         = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_full_scale();
    test_min_above_max();
    test_zero_step();
    test_backpressure();
    test_random_ramps(1100);

    drain_outputs();
    repeat (10) @(posedge clk);
    if (expected_colors.size() != 0)
      report_mismatch($sformatf("%0d words never arrived", expected_colors.size()));
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #600000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
